[design/contrast_adaptive_sharpen_3x3_assert.svh]
// Assertion macros for the contrast adaptive sharpening block.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef CONTRAST_ADAPTIVE_SHARPEN_3X3_ASSERT_SVH
`define CONTRAST_ADAPTIVE_SHARPEN_3X3_ASSERT_SVH

// same-cycle implication
`define CAS3_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CAS3_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/cas3_pkg.sv]
// Shared types and constants of the contrast adaptive sharpening block.
// No dependencies.
package cas3_pkg;
	localparam int PIX_W          = 16;
	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int PIXEL_BITS_DEF = 16;
	localparam int ROW_W          = 12;
	localparam int GEOM_W         = 13;
	localparam int HEIGHT_MAX     = 4096;
	localparam int CFG_W          = 17;
	localparam int IDX_W          = 3;
	localparam int DIV_NW         = 40;
	localparam int DIV_DW         = 21;
	localparam int SQ_W           = 34;
	localparam int SQ_STEPS       = 17;

	localparam logic [IDX_W-1:0] REG_PEAK   = 3'd0;
	localparam logic [IDX_W-1:0] REG_LIMIT  = 3'd1;
	localparam logic [IDX_W-1:0] REG_WEIGHT = 3'd2;
	localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd3;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd4;

	localparam logic [15:0]        PEAK_RST   = 16'd255;
	localparam logic [16:0]        LIMIT_RST  = 17'd510;
	localparam logic signed [16:0] WEIGHT_RST = -17'sd8192;
	localparam logic [GEOM_W-1:0]  WIDTH_RST  = 13'd1920;
	localparam logic [GEOM_W-1:0]  HEIGHT_RST = 13'd1080;

	typedef enum logic [2:0] {
		T_IDLE, T_LOAD, T_START, T_CALC, T_OUT
	} top_state_t;

	typedef enum logic [3:0] {
		C_IDLE, C_RANGE, C_RATIO, C_RDIV, C_SQRT, C_WMUL,
		C_NMUL, C_SIGN, C_TDIV, C_QDIV, C_DONE
	} core_state_t;
endpackage

[design/contrast_adaptive_sharpen_3x3.sv]
// Contrast adaptive sharpening over a 3x3 mirrored window, one plane in raster
// order. Each input transfer reads and updates the two line stores and shifts
// the window; each result it causes (none to four) then takes up to two 40-step
// serial divisions and a 17-step square root in the shared arithmetic core.
// Results lag one row and one column; the last column and the last row flush the
// right column and the bottom row alongside. Line store entries are not cleared
// after reset, so the first frame must start at row 0.
`include "contrast_adaptive_sharpen_3x3_assert.svh"

module contrast_adaptive_sharpen_3x3 #(
	parameter int MAX_WIDTH  = cas3_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = cas3_pkg::PIXEL_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [cas3_pkg::IDX_W-1:0]  cfg_index,
	input  logic [cas3_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [15:0]                 s_tdata,   // pixel_in
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [15:0]                 m_tdata,   // pixel_out
	output logic [1:0]                  m_tuser,   // row_end, frame_end
	output logic                        m_tlast    // last_of_run
);
	import cas3_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int FW = (CW + 1 > GEOM_W) ? CW + 1 : GEOM_W;
	localparam logic [PIX_W-1:0] PEAK_CAP = PIX_W'((32'd1 << PIXEL_BITS) - 1);

	top_state_t state_q, state_d;

	logic [15:0]         peak_q;
	logic [16:0]         limit_q;
	logic signed [16:0]  weight_q;
	logic [GEOM_W-1:0]   fw_q, fh_q;

	logic [CW-1:0]       col_q;
	logic [ROW_W-1:0]    row_q;
	logic [PIXEL_BITS-1:0] pix_q;
	logic [PIXEL_BITS-1:0] win_q [3][3];
	logic [3:0]          mask_q;
	logic [1:0]          emi_q;
	logic                up_q, lf_q;
	logic [PIX_W-1:0]    out_pix_q;
	logic                out_rend_q, out_fend_q;

	logic ram_we, core_start, core_done;
	logic [PIXEL_BITS-1:0] ram_a_rd, ram_b_rd;
	logic [PIX_W-1:0] core_res;

	// geometry
	logic [FW-1:0]     fw, wd;
	logic [GEOM_W-1:0] ht;
	logic              last_col, last_row;
	assign fw = FW'(fw_q);
	assign wd = (fw < FW'(2)) ? FW'(2) : (fw > FW'(MAX_WIDTH)) ? FW'(MAX_WIDTH) : fw;
	assign ht = (fh_q < GEOM_W'(2)) ? GEOM_W'(2)
		: (fh_q > GEOM_W'(HEIGHT_MAX)) ? GEOM_W'(HEIGHT_MAX) : fh_q;
	assign last_col = FW'(col_q) >= wd - FW'(1);
	assign last_row = GEOM_W'(row_q) >= ht - GEOM_W'(1);

	logic [3:0] mask_new, mask_rest;
	logic       r_ge1, c_ge1;
	assign r_ge1    = row_q != '0;
	assign c_ge1    = col_q != '0;
	assign mask_new = {r_ge1 && last_row && last_col, r_ge1 && last_row && c_ge1,
		r_ge1 && last_col, r_ge1 && c_ge1};
	assign mask_rest = mask_q & ~(4'b0001 << emi_q);

	function automatic logic [1:0] first_set(input logic [3:0] m);
		if (m[0]) return 2'd0;
		else if (m[1]) return 2'd1;
		else if (m[2]) return 2'd2;
		else return 2'd3;
	endfunction

	// window taps of the current emission
	logic [1:0] rsel [3];
	logic [1:0] csel [3];
	logic [8:0][PIX_W-1:0] core_win;
	always_comb begin
		if (!emi_q[1]) begin
			rsel[0] = up_q ? 2'd2 : 2'd0; rsel[1] = 2'd1; rsel[2] = 2'd2;
		end else begin
			rsel[0] = 2'd1; rsel[1] = 2'd2; rsel[2] = 2'd1;
		end
		if (!emi_q[0]) begin
			csel[0] = lf_q ? 2'd2 : 2'd0; csel[1] = 2'd1; csel[2] = 2'd2;
		end else begin
			csel[0] = 2'd1; csel[1] = 2'd2; csel[2] = 2'd1;
		end
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				core_win[r*3+k] = PIX_W'(win_q[rsel[r]][csel[k]]);
			end
		end
	end

	cas3_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_ram_a (
		.clk (clk), .we (ram_we), .addr (col_q), .wdata (pix_q), .rdata (ram_a_rd)
	);

	cas3_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_ram_b (
		.clk (clk), .we (ram_we), .addr (col_q), .wdata (ram_a_rd), .rdata (ram_b_rd)
	);

	cas3_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (core_start),
		.win    (core_win),
		.peak   ((peak_q > PEAK_CAP) ? PEAK_CAP : peak_q),
		.limit  (limit_q),
		.weight (weight_q),
		.done   (core_done),
		.result (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		m_tvalid   = 1'b0;
		ram_we     = 1'b0;
		core_start = 1'b0;
		unique case (state_q)
			T_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = T_LOAD;
			end
			T_LOAD: begin
				ram_we  = 1'b1;
				state_d = (mask_new == '0) ? T_IDLE : T_START;
			end
			T_START: begin
				core_start = 1'b1;
				state_d    = T_CALC;
			end
			T_CALC: if (core_done) state_d = T_OUT;
			T_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready) state_d = (mask_rest == '0) ? T_IDLE : T_START;
			end
			default: state_d = T_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q   <= PEAK_RST;
			limit_q  <= LIMIT_RST;
			weight_q <= WEIGHT_RST;
			fw_q     <= WIDTH_RST;
			fh_q     <= HEIGHT_RST;
			col_q    <= '0;
			row_q    <= '0;
			mask_q   <= '0;
			emi_q    <= '0;
			up_q     <= 1'b0;
			lf_q     <= 1'b0;
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					win_q[r][k] <= '0;
				end
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_PEAK:   peak_q   <= cfg_data[15:0];
					REG_LIMIT:  limit_q  <= cfg_data;
					REG_WEIGHT: weight_q <= $signed(cfg_data);
					REG_WIDTH:  fw_q     <= cfg_data[GEOM_W-1:0];
					REG_HEIGHT: fh_q     <= cfg_data[GEOM_W-1:0];
					default: ;
				endcase
			end
			if (state_q == T_LOAD) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r][0] <= win_q[r][1];
					win_q[r][1] <= win_q[r][2];
				end
				win_q[0][2] <= ram_b_rd;
				win_q[1][2] <= ram_a_rd;
				win_q[2][2] <= pix_q;
				mask_q <= mask_new;
				emi_q  <= first_set(mask_new);
				up_q   <= row_q == ROW_W'(1);
				lf_q   <= col_q == CW'(1);
				// advance raster position, wrap at frame end
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (state_q == T_OUT && m_tready) begin
				mask_q <= mask_rest;
				emi_q  <= first_set(mask_rest);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pix_q <= s_tdata[PIXEL_BITS-1:0];
		end
		if (state_q == T_CALC && core_done) begin
			out_pix_q  <= core_res;
			out_rend_q <= emi_q[0];
			out_fend_q <= emi_q == 2'd3;
		end
	end

	assign m_tdata = out_pix_q;
	assign m_tuser = {out_fend_q, out_rend_q};
	assign m_tlast = mask_rest == '0;

	`CAS3_ASSERT_IMP(a_one_side, s_tready, !m_tvalid, "input and output open together")
	`CAS3_ASSERT_IMP(a_done_calc, core_done, state_q == T_CALC, "core result while not waiting")
	`CAS3_ASSERT_NXT(a_run_end, m_tvalid && m_tready && m_tlast, s_tready,
		"run end not followed by idle")
	`CAS3_ASSERT_IMP(a_frame_end, m_tvalid && m_tuser[1], m_tuser[0] && m_tlast,
		"frame end off a row end")
endmodule

[design/cas3_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module cas3_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

[design/cas3_div.sv]
// Restoring serial divider, one quotient bit per cycle.
// Depends on cas3_pkg.
module cas3_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cas3_pkg::DIV_NW-1:0] dividend,
	input  logic [cas3_pkg::DIV_DW-1:0] divisor,
	output logic                        done,
	output logic [cas3_pkg::DIV_NW-1:0] quo
);
	import cas3_pkg::*;

	localparam int CNT_W = $clog2(DIV_NW + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q, done_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] rem_q, dvs_q;
	logic [DIV_DW:0]   rem_sh;
	logic              ge;

	assign rem_sh = {rem_q, quo_q[DIV_NW-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_DW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

[design/cas3_core.sv]
// Sharpening arithmetic for one 3x3 window: soft min/max, ratio, square root,
// weight and the final rounded division. Depends on cas3_pkg and cas3_div.
module cas3_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [8:0][cas3_pkg::PIX_W-1:0]       win,
	input  logic [cas3_pkg::PIX_W-1:0]            peak,
	input  logic [16:0]                           limit,
	input  logic signed [16:0]                    weight,
	output logic                                  done,
	output logic [cas3_pkg::PIX_W-1:0]            result
);
	import cas3_pkg::*;

	core_state_t state_q, state_d;

	logic [8:0][PIX_W-1:0]  px_q;
	logic [PIX_W:0]         mn_q, mx_q;
	logic [PIX_W+1:0]       s_q;
	logic [PIX_W-1:0]       e_q;
	logic [SQ_W-1:0]        sq_v_q, sq_res_q, sq_bit_q;
	logic [4:0]             sq_cnt_q;
	logic signed [17:0]     w_q;
	logic signed [37:0]     num_q, nn_q;
	logic signed [19:0]     den_q, dd_q;
	logic [PIX_W-1:0]       res_q;

	// window minima and maxima
	logic [PIX_W-1:0] cmin, cmax, wmin, wmax;
	always_comb begin
		cmin = px_q[4];
		cmax = px_q[4];
		for (int k = 1; k < 9; k += 2) begin
			if (px_q[k] < cmin) cmin = px_q[k];
			if (px_q[k] > cmax) cmax = px_q[k];
		end
		wmin = cmin;
		wmax = cmax;
		for (int k = 0; k < 9; k += 2) begin
			if (px_q[k] < wmin) wmin = px_q[k];
			if (px_q[k] > wmax) wmax = px_q[k];
		end
	end

	logic signed [17:0] lim, lo, mx_s;
	logic               ratio_zero, ratio_full;
	assign mx_s       = $signed({1'b0, mx_q});
	assign lim        = $signed({1'b0, limit}) - mx_s;
	assign lo         = ($signed({1'b0, mn_q}) < lim) ? $signed({1'b0, mn_q}) : lim;
	assign ratio_zero = (mx_q == '0) || (lo <= 18'sd0);
	assign ratio_full = lo >= mx_s;

	logic [SQ_W-1:0] sq_sum;
	logic            sq_ge;
	assign sq_sum = sq_res_q + sq_bit_q;
	assign sq_ge  = sq_v_q >= sq_sum;

	logic [16:0] mag;
	logic [33:0] prod;
	assign mag  = weight[16] ? 17'(-weight) : 17'(weight);
	assign prod = sq_res_q[16:0] * mag;

	logic signed [36:0] ws;
	assign ws = w_q * $signed({1'b0, s_q});

	logic signed [39:0] t;
	assign t = ($signed(40'(nn_q)) <<< 1) + $signed(40'(dd_q));

	logic                div_start, div_done;
	logic [DIV_NW-1:0]   div_nd, div_q;
	logic [DIV_DW-1:0]   div_dv;

	cas3_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_nd),
		.divisor  (div_dv),
		.done     (div_done),
		.quo      (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_nd    = DIV_NW'({mn_q, 16'b0});
		div_dv    = DIV_DW'(mx_q);
		done      = 1'b0;
		unique case (state_q)
			C_IDLE: if (start) state_d = C_RANGE;
			C_RANGE: state_d = C_RATIO;
			C_RATIO: begin
				if (ratio_zero || ratio_full) begin
					state_d = C_SQRT;
				end else begin
					div_start = 1'b1;
					div_nd    = DIV_NW'({lo[16:0], 16'b0});
					state_d   = C_RDIV;
				end
			end
			C_RDIV: if (div_done) state_d = C_SQRT;
			C_SQRT: if (sq_cnt_q == 5'd1) state_d = C_WMUL;
			C_WMUL: state_d = C_NMUL;
			C_NMUL: state_d = C_SIGN;
			C_SIGN: state_d = C_TDIV;
			C_TDIV: begin
				if (dd_q == '0 || t[39]) begin
					state_d = C_DONE;
				end else begin
					div_start = 1'b1;
					div_nd    = t;
					div_dv    = {dd_q[19:0], 1'b0};
					state_d   = C_QDIV;
				end
			end
			C_QDIV: if (div_done) state_d = C_DONE;
			C_DONE: begin
				done    = 1'b1;
				state_d = C_IDLE;
			end
			default: state_d = C_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: if (start) px_q <= win;
			C_RANGE: begin
				mn_q <= {1'b0, cmin} + {1'b0, wmin};
				mx_q <= {1'b0, cmax} + {1'b0, wmax};
				s_q  <= 18'(px_q[1]) + 18'(px_q[3]) + 18'(px_q[5]) + 18'(px_q[7]);
				e_q  <= px_q[4];
			end
			C_RATIO: begin
				sq_res_q <= '0;
				sq_bit_q <= SQ_W'(1) << 32;
				sq_cnt_q <= 5'(SQ_STEPS);
				sq_v_q   <= ratio_zero ? '0 : SQ_W'(1) << 32;
			end
			C_RDIV: if (div_done) sq_v_q <= SQ_W'({div_q[16:0], 16'b0});
			C_SQRT: begin
				sq_v_q   <= sq_ge ? sq_v_q - sq_sum : sq_v_q;
				sq_res_q <= sq_ge ? (sq_res_q >> 1) + sq_bit_q : sq_res_q >> 1;
				sq_bit_q <= sq_bit_q >> 2;
				sq_cnt_q <= sq_cnt_q - 5'd1;
			end
			C_WMUL: w_q <= weight[16] ? -$signed({1'b0, prod[32:16]})
				: $signed({1'b0, prod[32:16]});
			C_NMUL: begin
				num_q <= $signed({6'b0, e_q, 16'b0}) + 38'(ws);
				den_q <= 20'sd65536 + (20'(w_q) <<< 2);
			end
			C_SIGN: begin
				nn_q <= den_q[19] ? -num_q : num_q;
				dd_q <= den_q[19] ? -den_q : den_q;
			end
			C_TDIV: begin
				// zero denominator: saturate by the numerator sign
				if (dd_q == '0) begin
					res_q <= (nn_q > 38'sd0) ? peak : '0;
				end else if (t[39]) begin
					res_q <= '0;
				end
			end
			C_QDIV: if (div_done) begin
				res_q <= (div_q > DIV_NW'(peak)) ? peak : div_q[PIX_W-1:0];
			end
			default: ;
		endcase
	end

	assign result = res_q;
endmodule
